/* rtl/stnk_pkg.sv */
package stnk_pkg;

   // quotient bits of 2^32 / den, one per divider stage
   localparam int DivSteps = 33;
   // positive-part sum of six saturated 32-bit values
   localparam int DenW = 35;
   // magnitude of a weighted sum of six truncated products
   localparam int MagW = 50;
   localparam int RemW = DenW + 1;

   typedef struct packed {
      logic [30:0]        tri_area;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] now_a;
      logic signed [31:0] now_b;
      logic signed [31:0] now_c;
      logic signed [31:0] prev_a;
      logic signed [31:0] prev_b;
      logic signed [31:0] prev_c;
   } stnk_req_type;

   typedef struct packed {
      logic signed [31:0] tilde_a;
      logic signed [31:0] tilde_b;
      logic signed [31:0] tilde_c;
      logic signed [31:0] hat_a;
      logic signed [31:0] hat_b;
      logic signed [31:0] hat_c;
      logic [30:0]        norm_factor;
      logic signed [31:0] inflow_sum;
      logic signed [31:0] outflow_sum;
      logic               zero_denominator;
   } stnk_rsp_type;

   // values that ride along the divider untouched
   typedef struct packed {
      logic [2:0][31:0] kt;
      logic [2:0][31:0] kh;
      logic [MagW-1:0]  mag_in;
      logic             neg_in;
      logic [MagW-1:0]  mag_out;
      logic             neg_out;
      logic             zero;
   } stnk_carry_type;

   typedef struct packed {
      logic           valid;
      logic [DenW-1:0] den;
      stnk_carry_type carry;
   } stnk_div_type;

   typedef struct packed {
      logic                valid;
      logic [DivSteps-1:0] quot;
      stnk_carry_type      carry;
   } stnk_div_out_type;

endpackage

/* rtl/stnk_recip.sv */
module stnk_recip (
   input  logic                      clock,
   input  logic                      reset,
   input  stnk_pkg::stnk_div_type     div_in,
   output stnk_pkg::stnk_div_out_type div_out
);
   import stnk_pkg::*;

   // one restoring step of 2^32 / den per stage
   logic                valid_ff [DivSteps];
   logic [RemW-1:0]     rem_ff   [DivSteps];
   logic [DivSteps-1:0] quot_ff  [DivSteps];
   logic [DenW-1:0]     den_ff   [DivSteps];
   stnk_carry_type      carry_ff [DivSteps];

   for (genvar j = 0; j < DivSteps; j++) begin : g_step
      logic                prev_valid;
      logic [RemW-1:0]     prev_rem;
      logic [DivSteps-1:0] prev_quot;
      logic [DenW-1:0]     prev_den;
      stnk_carry_type      prev_carry;
      logic [RemW-1:0]     shifted;
      logic                take;
      logic [RemW-1:0]     rem_in;
      logic [DivSteps-1:0] quot_in;

      if (j == 0) begin : g_first
         assign prev_valid = div_in.valid;
         assign prev_rem   = '0;
         assign prev_quot  = '0;
         assign prev_den   = div_in.den;
         assign prev_carry = div_in.carry;
      end else begin : g_next
         assign prev_valid = valid_ff[j-1];
         assign prev_rem   = rem_ff[j-1];
         assign prev_quot  = quot_ff[j-1];
         assign prev_den   = den_ff[j-1];
         assign prev_carry = carry_ff[j-1];
      end

      // numerator bit: only the top one of 2^32 is set
      assign shifted = {prev_rem[RemW-2:0], (j == 0) ? 1'b1 : 1'b0};
      assign take    = shifted >= {1'b0, prev_den};
      assign rem_in  = take ? shifted - {1'b0, prev_den} : shifted;
      assign quot_in = {prev_quot[DivSteps-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= prev_valid;
         end
         rem_ff[j]   <= rem_in;
         quot_ff[j]  <= quot_in;
         den_ff[j]   <= prev_den;
         carry_ff[j] <= prev_carry;
      end
   end

   assign div_out.valid = valid_ff[DivSteps-1];
   assign div_out.quot  = quot_ff[DivSteps-1];
   assign div_out.carry = carry_ff[DivSteps-1];

endmodule

/* rtl/space_time_n_scheme_triangle_kernel_top.sv */
// space-time n-scheme kernel, one triangle per transfer
//
// input channel: an item (area, three coefficients k, current and previous
// nodal values) is taken at a rising edge where start is high and busy is
// low. busy is always low, so a new triangle may be issued every cycle.
// result channel: rsp_valid is high for exactly one cycle with rsp_data;
// the receiver must take it then, there is no back-pressure.
// config port: apb-style, time_step at byte address 0, a setup phase then
// an access phase, pready always high. write it only while the pipeline is
// empty.
// throughput: one triangle per cycle. the pipeline is the 33-stage
// restoring divider that forms 2^32 / den, one quotient bit per stage,
// plus eight arithmetic stages around it.
// reset: synchronous, clears all valid bits (in-flight items are dropped)
// and sets time_step to zero.
module space_time_n_scheme_triangle_kernel_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  stnk_pkg::stnk_req_type req_data,
   output logic                   rsp_valid,
   output stnk_pkg::stnk_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import stnk_pkg::*;

   localparam logic RegTimeStep = 1'b0;
   localparam int   Latency = 8 + DivSteps;
   // ceil(2^33 / 3): area * this >> 33 is area / 3 for any 32-bit area
   localparam logic [31:0] ThirdRecip = 32'hAAAAAAAB;

   // ---------------- configuration register ----------------
   logic [30:0] time_step_ff;
   logic        reg_hit;

   assign reg_hit = paddr[2] == RegTimeStep;
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? {1'b0, time_step_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
      end else if (psel && penable && pwrite && reg_hit) begin
         time_step_ff <= pwdata[30:0];
      end
   end

   // the pipeline never holds off a transfer
   assign busy = 1'b0;

   function automatic logic signed [31:0] sat32(input logic signed [46:0] x);
      if (x > 47'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (x < -47'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // recombine the split product of magnitude and N, sign and saturate
   function automatic logic signed [31:0] scale_fin(input logic [55:0] hi_p,
                                                    input logic [55:0] lo_p,
                                                    input logic        neg);
      logic [40:0] r;
      r = 41'({hi_p[22:0], 9'd0}) + 41'(lo_p[55:16]);
      if (hi_p >= 56'd8388608) begin
         return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (!neg) begin
         return (r > 41'd2147483647) ? 32'sh7FFFFFFF : r[31:0];
      end
      return (r > 41'd2147483648) ? 32'sh80000000 : 32'(-r);
   endfunction

   // ---------------- stage 1: dt*k and area/3 ----------------
   logic signed [31:0] coef_w [3];
   logic signed [31:0] now_w  [3];
   logic signed [31:0] prev_w [3];
   logic               v1_ff;
   logic signed [62:0] prod1_ff [3];
   logic signed [62:0] prod1_in [3];
   logic [29:0]        third1_ff;
   logic [62:0]        third_prod;
   logic signed [31:0] now1_ff  [3];
   logic signed [31:0] prev1_ff [3];

   assign coef_w = '{req_data.coef_a, req_data.coef_b, req_data.coef_c};
   assign now_w  = '{req_data.now_a, req_data.now_b, req_data.now_c};
   assign prev_w = '{req_data.prev_a, req_data.prev_b, req_data.prev_c};
   assign third_prod = 63'(req_data.tri_area) * 63'(ThirdRecip);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = 63'($signed({1'b0, time_step_ff}) * coef_w[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      prod1_ff  <= prod1_in;
      third1_ff <= third_prod[62:33];
      now1_ff   <= now_w;
      prev1_ff  <= prev_w;
   end

   // ---------------- stage 2: kTilde and kHat ----------------
   logic               v2_ff;
   logic signed [31:0] kt2_ff [3];
   logic signed [31:0] kh2_ff [3];
   logic signed [31:0] kt2_in [3];
   logic signed [31:0] kh2_in [3];
   logic signed [31:0] now2_ff  [3];
   logic signed [31:0] prev2_ff [3];

   always_comb begin
      logic signed [62:0] rnd;
      logic signed [45:0] half;
      logic signed [46:0] third_s;
      for (int i = 0; i < 3; i++) begin
         // divide by 2^17 toward zero
         rnd  = prod1_ff[i] + (prod1_ff[i][62] ? 63'sd131071 : 63'sd0);
         half = 46'(rnd >>> 17);
         third_s = $signed({17'd0, third1_ff});
         kt2_in[i] = sat32(47'(half) + third_s);
         kh2_in[i] = sat32(47'(half) - third_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      kt2_ff   <= kt2_in;
      kh2_ff   <= kh2_in;
      now2_ff  <= now1_ff;
      prev2_ff <= prev1_ff;
   end

   // ---------------- stage 3: weighted products and denominator ----------------
   // even entries kTilde*now, odd entries kHat*prev
   logic               v3_ff;
   logic signed [63:0] p3_ff [6];
   logic signed [63:0] p3_in [6];
   logic               pos3_ff [6];
   logic               pos3_in [6];
   logic [DenW-1:0]    den3_ff;
   logic [DenW-1:0]    den3_in;
   logic signed [31:0] kt3_ff [3];
   logic signed [31:0] kh3_ff [3];

   always_comb begin
      den3_in = '0;
      for (int i = 0; i < 3; i++) begin
         p3_in[2*i]     = kt2_ff[i] * now2_ff[i];
         p3_in[2*i+1]   = kh2_ff[i] * prev2_ff[i];
         pos3_in[2*i]   = kt2_ff[i] > 32'sd0;
         pos3_in[2*i+1] = kh2_ff[i] > 32'sd0;
         if (pos3_in[2*i]) begin
            den3_in = den3_in + DenW'(kt2_ff[i][30:0]);
         end
         if (pos3_in[2*i+1]) begin
            den3_in = den3_in + DenW'(kh2_ff[i][30:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      p3_ff   <= p3_in;
      pos3_ff <= pos3_in;
      den3_ff <= den3_in;
      kt3_ff  <= kt2_ff;
      kh3_ff  <= kh2_ff;
   end

   // ---------------- stage 4: truncate products by 2^16 ----------------
   logic               v4_ff;
   logic signed [47:0] t4_ff [6];
   logic signed [47:0] t4_in [6];
   logic               pos4_ff [6];
   logic [DenW-1:0]    den4_ff;
   logic signed [31:0] kt4_ff [3];
   logic signed [31:0] kh4_ff [3];

   always_comb begin
      logic signed [63:0] rnd;
      for (int i = 0; i < 6; i++) begin
         rnd = p3_ff[i] + (p3_ff[i][63] ? 64'sd65535 : 64'sd0);
         t4_in[i] = 48'(rnd >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      t4_ff   <= t4_in;
      pos4_ff <= pos3_ff;
      den4_ff <= den3_ff;
      kt4_ff  <= kt3_ff;
      kh4_ff  <= kh3_ff;
   end

   // ---------------- stage 5: inflow and outflow sums ----------------
   logic               v5_ff;
   logic signed [50:0] s_in5_ff;
   logic signed [50:0] s_out5_ff;
   logic signed [50:0] s_in5_in;
   logic signed [50:0] s_out5_in;
   logic [DenW-1:0]    den5_ff;
   logic signed [31:0] kt5_ff [3];
   logic signed [31:0] kh5_ff [3];

   always_comb begin
      s_in5_in  = '0;
      s_out5_in = '0;
      for (int i = 0; i < 6; i++) begin
         if (pos4_ff[i]) begin
            s_out5_in = s_out5_in + 51'(t4_ff[i]);
         end else begin
            s_in5_in = s_in5_in + 51'(t4_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      s_in5_ff  <= s_in5_in;
      s_out5_ff <= s_out5_in;
      den5_ff   <= den4_ff;
      kt5_ff    <= kt4_ff;
      kh5_ff    <= kh4_ff;
   end

   // ---------------- stage 6: magnitudes, divider entry ----------------
   stnk_div_type     div_in_ff;
   stnk_div_type     div_in_in;
   stnk_div_out_type div_out;

   always_comb begin
      logic signed [50:0] neg_in_sum;
      neg_in_sum = -s_in5_ff;
      div_in_in.valid = v5_ff;
      div_in_in.den   = den5_ff;
      for (int i = 0; i < 3; i++) begin
         div_in_in.carry.kt[i] = kt5_ff[i];
         div_in_in.carry.kh[i] = kh5_ff[i];
      end
      div_in_in.carry.neg_in  = neg_in_sum[50];
      div_in_in.carry.mag_in  = MagW'(neg_in_sum[50] ? s_in5_ff : neg_in_sum);
      div_in_in.carry.neg_out = s_out5_ff[50];
      div_in_in.carry.mag_out = MagW'(s_out5_ff[50] ? -s_out5_ff : s_out5_ff);
      div_in_in.carry.zero    = den5_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_in_ff.valid <= 1'b0;
      end else begin
         div_in_ff.valid <= div_in_in.valid;
      end
      div_in_ff.den   <= div_in_in.den;
      div_in_ff.carry <= div_in_in.carry;
   end

   stnk_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in_ff),
      .div_out (div_out)
   );

   // ---------------- stage P: saturate N, split products ----------------
   logic             vp_ff;
   logic [55:0]      a_in_ff, b_in_ff, a_out_ff, b_out_ff;
   logic [30:0]      norm_p_ff;
   logic [30:0]      norm_p;
   stnk_carry_type   carry_p_ff;

   always_comb begin
      if (div_out.carry.zero) begin
         norm_p = '0;
      end else if (div_out.quot > DivSteps'(32'h7FFFFFFF)) begin
         norm_p = 31'h7FFFFFFF;
      end else begin
         norm_p = div_out.quot[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= div_out.valid;
      end
      a_in_ff    <= 56'(div_out.carry.mag_in[MagW-1:25]) * 56'(norm_p);
      b_in_ff    <= 56'(div_out.carry.mag_in[24:0]) * 56'(norm_p);
      a_out_ff   <= 56'(div_out.carry.mag_out[MagW-1:25]) * 56'(norm_p);
      b_out_ff   <= 56'(div_out.carry.mag_out[24:0]) * 56'(norm_p);
      norm_p_ff  <= norm_p;
      carry_p_ff <= div_out.carry;
   end

   // ---------------- output register ----------------
   logic         rsp_valid_ff;
   stnk_rsp_type rsp_ff;
   stnk_rsp_type rsp_in;

   always_comb begin
      rsp_in.tilde_a          = carry_p_ff.kt[0];
      rsp_in.tilde_b          = carry_p_ff.kt[1];
      rsp_in.tilde_c          = carry_p_ff.kt[2];
      rsp_in.hat_a            = carry_p_ff.kh[0];
      rsp_in.hat_b            = carry_p_ff.kh[1];
      rsp_in.hat_c            = carry_p_ff.kh[2];
      rsp_in.norm_factor      = norm_p_ff;
      rsp_in.inflow_sum       = scale_fin(a_in_ff, b_in_ff, carry_p_ff.neg_in);
      rsp_in.outflow_sum      = scale_fin(a_out_ff, b_out_ff, carry_p_ff.neg_out);
      rsp_in.zero_denominator = carry_p_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vp_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   // every accepted triangle comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##Latency rsp_valid)
      else $error("result missing after pipeline latency");

   // zero denominator only when no kTilde or kHat is positive
   a_zero_signs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.tilde_a <= 0 && rsp_data.tilde_b <= 0 && rsp_data.tilde_c <= 0 &&
         rsp_data.hat_a <= 0 && rsp_data.hat_b <= 0 && rsp_data.hat_c <= 0)
      else $error("zero denominator with a positive part");

   // a zero denominator clears N and both flows
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.norm_factor == 0 && rsp_data.inflow_sum == 0 &&
         rsp_data.outflow_sum == 0)
      else $error("nonzero flow with zero denominator");

   // divider output reaches rsp_valid through the stage P and output registers
   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> ##2 rsp_valid)
      else $error("divider result lost");

endmodule

/* tb/space_time_n_scheme_triangle_kernel_top_test.sv */
module space_time_n_scheme_triangle_kernel_top_test;
   import stnk_pkg::*;

   localparam logic [2:0] RegTimeStep = 3'd0;
   // pipeline depth given by the block, plus margin
   localparam int DrainCycles = 50;
   localparam int NumRandom = 1420;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   stnk_req_type req_data;
   logic         rsp_valid;
   stnk_rsp_type rsp_data;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   space_time_n_scheme_triangle_kernel_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // time step as seen by the kernel, tracked by the testbench
   logic [30:0]  dt_shadow;
   // results still in flight through the pipeline
   stnk_rsp_type pending_rsp[$];
   int           err_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous fixed limit: 1445 items, random gaps between them, pipeline drains
   initial begin
      #200000;
      $display("space_time_n_scheme_triangle_kernel_top_test: errors");
      $finish;
   end

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // |s| * n / 2^16 toward zero, signed and saturated; n below 2^31
   function automatic longint scale_norm(longint s, longint n);
      logic      neg;
      logic [127:0] mag;
      neg = s < 0;
      mag = neg ? 128'(-s) : 128'(s);
      mag = (mag * 128'(n)) >> 16;
      if (mag > 128'h7FFF_FFFF && !neg) return 64'sd2147483647;
      if (mag > 128'h8000_0000 && neg) return -64'sd2147483648;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // n-scheme kernel for one triangle
   function automatic stnk_rsp_type n_scheme(stnk_req_type t, logic [30:0] dt);
      stnk_rsp_type r;
      longint       third, half, den, s_in, s_out, norm;
      longint       kt[3], kh[3], kv[3], nv[3], pv[3];
      den = 0;
      s_in = 0;
      s_out = 0;
      norm = 0;
      third = longint'(t.tri_area) / 3;
      kv = '{longint'(t.coef_a), longint'(t.coef_b), longint'(t.coef_c)};
      nv = '{longint'(t.now_a), longint'(t.now_b), longint'(t.now_c)};
      pv = '{longint'(t.prev_a), longint'(t.prev_b), longint'(t.prev_c)};
      for (int i = 0; i < 3; i++) begin
         half = (longint'(dt) * kv[i]) / 131072;
         kt[i] = clip32(half + third);
         kh[i] = clip32(half - third);
         // weighted terms truncated toward zero, split by sign of the weight
         if (kt[i] > 0) begin
            den += kt[i];
            s_out += (kt[i] * nv[i]) / 65536;
         end else begin
            s_in += (kt[i] * nv[i]) / 65536;
         end
         if (kh[i] > 0) begin
            den += kh[i];
            s_out += (kh[i] * pv[i]) / 65536;
         end else begin
            s_in += (kh[i] * pv[i]) / 65536;
         end
      end
      r.tilde_a = kt[0][31:0];
      r.tilde_b = kt[1][31:0];
      r.tilde_c = kt[2][31:0];
      r.hat_a = kh[0][31:0];
      r.hat_b = kh[1][31:0];
      r.hat_c = kh[2][31:0];
      r.zero_denominator = (den == 0);
      r.norm_factor = '0;
      r.inflow_sum = '0;
      r.outflow_sum = '0;
      if (den != 0) begin
         norm = 64'sd4294967296 / den;
         if (norm > 64'sd2147483647) norm = 64'sd2147483647;
         r.norm_factor = norm[30:0];
         r.inflow_sum = 32'(scale_norm(-s_in, norm));
         r.outflow_sum = 32'(scale_norm(s_out, norm));
      end
      return r;
   endfunction

   // result monitor: every strobe must match the oldest expectation
   always @(posedge clock) begin
      stnk_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.tilde_a !== want.tilde_a)
               $display("%0t tilde_a exp %h got %h", $time, want.tilde_a, rsp_data.tilde_a);
            if (rsp_data.tilde_b !== want.tilde_b)
               $display("%0t tilde_b exp %h got %h", $time, want.tilde_b, rsp_data.tilde_b);
            if (rsp_data.tilde_c !== want.tilde_c)
               $display("%0t tilde_c exp %h got %h", $time, want.tilde_c, rsp_data.tilde_c);
            if (rsp_data.hat_a !== want.hat_a)
               $display("%0t hat_a exp %h got %h", $time, want.hat_a, rsp_data.hat_a);
            if (rsp_data.hat_b !== want.hat_b)
               $display("%0t hat_b exp %h got %h", $time, want.hat_b, rsp_data.hat_b);
            if (rsp_data.hat_c !== want.hat_c)
               $display("%0t hat_c exp %h got %h", $time, want.hat_c, rsp_data.hat_c);
            if (rsp_data.norm_factor !== want.norm_factor)
               $display("%0t norm_factor exp %h got %h", $time, want.norm_factor,
                        rsp_data.norm_factor);
            if (rsp_data.inflow_sum !== want.inflow_sum)
               $display("%0t inflow_sum exp %h got %h", $time, want.inflow_sum,
                        rsp_data.inflow_sum);
            if (rsp_data.outflow_sum !== want.outflow_sum)
               $display("%0t outflow_sum exp %h got %h", $time, want.outflow_sum,
                        rsp_data.outflow_sum);
            if (rsp_data.zero_denominator !== want.zero_denominator)
               $display("%0t zero_denominator exp %b got %b", $time,
                        want.zero_denominator, rsp_data.zero_denominator);
            if (rsp_data !== want) err_count++;
         end
      end
   end

   // csr write: setup then access, register takes it on the access edge
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == RegTimeStep) dt_shadow = data[30:0];
   endtask

   // one transfer on the request side, after the gap given by the caller
   task automatic issue_triangle(stnk_req_type t, int gap);
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(n_scheme(t, dt_shadow));
   endtask

   // wait for the pipeline to empty before touching the register
   task automatic drain;
      int guard;
      start <= 1'b0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< 16;
         3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic stnk_req_type random_triangle();
      stnk_req_type t;
      case ($urandom_range(0, 3))
         0: t.tri_area = 31'($urandom_range(0, 3));
         1: t.tri_area = 31'h7FFF_FFFF;
         2: t.tri_area = 31'($urandom_range(0, 32'h000F_FFFF));
         default: t.tri_area = 31'($urandom);
      endcase
      t.coef_a = pick_value();
      t.coef_b = pick_value();
      t.coef_c = pick_value();
      t.now_a = pick_value();
      t.now_b = pick_value();
      t.now_c = pick_value();
      t.prev_a = pick_value();
      t.prev_b = pick_value();
      t.prev_c = pick_value();
      return t;
   endfunction

   typedef struct {
      stnk_req_type stim;
      logic         known;   // expected result typed in below
      stnk_rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   initial begin
      logic [30:0]  dt_sweep[5];
      stnk_req_type t;
      stnk_rsp_type w;
      err_count = 0;
      dt_shadow = '0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, time step still at its reset value of zero
      // all zero: zero denominator, every result zero
      t = '0;
      w = '0;
      w.zero_denominator = 1'b1;
      directed_rows.push_back('{t, 1'b1, w});
      // area 3 with dt zero: tilde 1, hat -1, den 3, n = 2^32/3
      t = '0;
      t.tri_area = 31'd3;
      w = '0;
      w.tilde_a = 32'sd1;
      w.tilde_b = 32'sd1;
      w.tilde_c = 32'sd1;
      w.hat_a = -32'sd1;
      w.hat_b = -32'sd1;
      w.hat_c = -32'sd1;
      w.norm_factor = 31'h5555_5555;
      directed_rows.push_back('{t, 1'b1, w});
      // largest area, extreme coefficients and values
      t = '{31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};
      directed_rows.push_back('{t, 1'b0, w});
      t = '{31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      directed_rows.push_back('{t, 1'b0, w});
      t = '{31'h5555_5555, 32'hFFFF_FFFF, 32'h1, 32'h0,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
      directed_rows.push_back('{t, 1'b0, w});

      // walk the table once per time step; dt extremes make saturation and
      // zero denominators reachable through k alone
      dt_sweep = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'd1, 31'h0000_8000};
      foreach (dt_sweep[s]) begin
         if (s > 0) csr_write(RegTimeStep, {1'b0, dt_sweep[s]});
         foreach (directed_rows[i]) begin
            if (s == 0 && directed_rows[i].known)
               w = n_scheme(directed_rows[i].stim, dt_shadow);
            if (s == 0 && directed_rows[i].known && w !== directed_rows[i].want) begin
               $display("%0t table row %0d exp %h got %h", $time, i,
                        directed_rows[i].want, w);
               err_count++;
            end
            issue_triangle(directed_rows[i].stim, 0);
         end
         drain;
      end

      // random phase: time step changes only with the pipeline empty
      for (int n = 0; n < NumRandom; n++) begin
         if (n % 300 == 0) begin
            drain;
            case ($urandom_range(0, 3))
               0: csr_write(RegTimeStep, 32'h7FFF_FFFF);
               1: csr_write(RegTimeStep, 32'd0);
               2: csr_write(RegTimeStep, $urandom_range(0, 32'h0004_0000));
               default: csr_write(RegTimeStep, $urandom);
            endcase
         end
         // runs of back-to-back transfers mixed with random gaps
         issue_triangle(random_triangle(), (n % 100 < 30) ? 0 : $urandom_range(0, 3));
      end

      start <= 1'b0;
      drain;
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("space_time_n_scheme_triangle_kernel_top_test: clean");
      end else begin
         $display("space_time_n_scheme_triangle_kernel_top_test: errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/stnk_pkg.sv
rtl/stnk_recip.sv
rtl/space_time_n_scheme_triangle_kernel_top.sv
tb/space_time_n_scheme_triangle_kernel_top_test.sv
